// File: rtl/pac_pkg.sv
// pac_pkg: shared constants for the probabilistic approximate counter.
// Register indexes, reset values and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pac_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_FIELD_W = 32;
  localparam int RAND_W     = 16;
  localparam int BETA_W     = 16;
  localparam int TP_W       = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_POINTS = 1'b0,
    REG_BETA         = 1'b1
  } cfg_reg_t;

  localparam logic [TP_W-1:0]   TP_RESET   = 32'd1;
  localparam logic [BETA_W-1:0] BETA_RESET = 16'd256;

endpackage
`default_nettype wire

// File: rtl/pac_log_cell.sv
// pac_log_cell: one fraction bit of the fixed-point log2 (square and compare).
// Carries a side payload along the chain. Uses pac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pac_log_cell #(
  parameter int LW = 21,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic [31:0]   m_i,
  input  wire logic [LW-1:0] res_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [31:0]        m_o,
  output logic [LW-1:0]      res_o,
  output logic [SW-1:0]      side_o
);
  import pac_pkg::*;

  logic [63:0]   sq;
  logic [32:0]   sq_sh;
  logic          vld_r, vld_nxt;
  logic [31:0]   m_r, m_nxt;
  logic [LW-1:0] res_r, res_nxt;
  logic [SW-1:0] side_r, side_nxt;

  always_comb begin
    sq       = m_i * m_i;
    sq_sh    = sq[63:31];
    vld_nxt  = vld_i;
    side_nxt = side_i;
    if (sq_sh[32]) begin
      m_nxt   = sq_sh[32:1];
      res_nxt = {res_i[LW-2:0], 1'b1};
    end else begin
      m_nxt   = sq_sh[31:0];
      res_nxt = {res_i[LW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    m_r    <= m_nxt;
    res_r  <= res_nxt;
    side_r <= side_nxt;
  end

  assign vld_o  = vld_r;
  assign m_o    = m_r;
  assign res_o  = res_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// File: rtl/pac_div_cell.sv
// pac_div_cell: one quotient bit of a restoring divider.
// Divisor and side payload travel with the item. Uses pac_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pac_div_cell #(
  parameter int LW = 21,
  parameter int NW = 56,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  wire logic [LW-1:0] dvs_i,
  input  wire logic [LW-1:0] rem_i,
  input  wire logic [NW-1:0] q_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [LW-1:0]      dvs_o,
  output logic [LW-1:0]      rem_o,
  output logic [NW-1:0]      q_o,
  output logic [SW-1:0]      side_o
);
  import pac_pkg::*;

  logic [LW:0]   trial;
  logic          vld_r;
  logic [LW-1:0] dvs_r, rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [SW-1:0] side_r;

  always_comb begin
    trial = {rem_i, q_i[NW-1]};
    if (trial >= {1'b0, dvs_i}) begin
      rem_nxt = LW'(trial - {1'b0, dvs_i});
      q_nxt   = {q_i[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[LW-1:0];
      q_nxt   = {q_i[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    dvs_r  <= dvs_i;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign dvs_o  = dvs_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

// File: rtl/probabilistic_approximate_counter.sv
// probabilistic_approximate_counter: top level, fully pipelined counter update.
// Depends on pac_pkg, pac_log_cell, pac_div_cell.
//
//  channel | ports                                                      | transfer when
//  --------+------------------------------------------------------------+---------------
//  input   | start, busy, in_mode, in_counter_value, in_random_fraction | start && !busy
//  result  | out_valid, out_new_value, out_updated                      | out_valid
//  config  | cfg_we, cfg_index, cfg_wdata                               | cfg_we
//
// One item per cycle. Stages: entry, the log2 chain (one fraction bit per cell),
// probability, decision, the restoring divider over the NW = 8 + CNT_W +
// LOG_FRAC_BITS dividend width (one quotient bit per cell) and the output register.
// Reset clears valid bits and restores the config registers. busy is always low;
// the receiver cannot stall, so nothing in the chain ever holds.
`timescale 1ns / 1ps
`default_nettype none
module probabilistic_approximate_counter #(
  parameter int LOG_FRAC_BITS = 16,
  parameter int COUNTER_BITS  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_mode,
  input  wire logic [pac_pkg::CNT_FIELD_W-1:0] in_counter_value,
  input  wire logic [pac_pkg::RAND_W-1:0]      in_random_fraction,
  output logic                                 out_valid,
  output logic [pac_pkg::CNT_FIELD_W-1:0]      out_new_value,
  output logic                                 out_updated,
  input  wire logic                            cfg_we,
  input  wire logic [pac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pac_pkg::*;

  localparam int CNT_W = (COUNTER_BITS > 32) ? 32 : COUNTER_BITS;
  localparam int LW    = 5 + LOG_FRAC_BITS;            // Q5.F log2
  localparam int NW    = BETA_W + CNT_W + LOG_FRAC_BITS - 8;
  localparam int LSW   = 1 + CNT_W + RAND_W + NW;      // side payload in log chain
  localparam int DSW   = 2 + CNT_W;                    // side payload in divider

  // config registers; the user must keep them stable while items are in flight (not enforced)
  logic [TP_W-1:0]   tp_r;
  logic [BETA_W-1:0] beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r   <= TP_RESET;
      beta_r <= BETA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOTAL_POINTS: tp_r   <= cfg_wdata[TP_W-1:0];
        REG_BETA:         beta_r <= cfg_wdata[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---- entry stage: beta*c product, log2 integer part, mantissa normalize
  logic [4:0]              k;
  logic [BETA_W+CNT_W-1:0] bc;
  logic                    s0_vld_r;
  logic [31:0]             s0_m_r;
  logic [LW-1:0]           s0_res_r;
  logic [LSW-1:0]          s0_side_r;

  always_comb begin
    k = 5'd0;
    for (int i = 1; i < TP_W; i++) begin
      if (tp_r[i]) k = 5'(i);
    end
    bc = beta_r * in_counter_value[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    // tp of 0 or 1 gives a mantissa that never crosses 2, so L stays 0
    s0_m_r    <= tp_r << (5'd31 - k);
    s0_res_r  <= LW'(k);
    s0_side_r <= {in_mode, in_counter_value[CNT_W-1:0], in_random_fraction,
                  NW'(bc) << (LOG_FRAC_BITS - 8)};
  end

  // ---- log2 fraction chain
  logic [LOG_FRAC_BITS:0]          lc_vld;
  logic [LOG_FRAC_BITS:0][31:0]    lc_m;
  logic [LOG_FRAC_BITS:0][LW-1:0]  lc_res;
  logic [LOG_FRAC_BITS:0][LSW-1:0] lc_side;

  assign lc_vld[0]  = s0_vld_r;
  assign lc_m[0]    = s0_m_r;
  assign lc_res[0]  = s0_res_r;
  assign lc_side[0] = s0_side_r;

  for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_log
    pac_log_cell #(.LW(LW), .SW(LSW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(lc_vld[g]), .m_i(lc_m[g]), .res_i(lc_res[g]), .side_i(lc_side[g]),
      .vld_o(lc_vld[g+1]), .m_o(lc_m[g+1]), .res_o(lc_res[g+1]),
      .side_o(lc_side[g+1])
    );
  end

  // ---- probability stage: r*N product and compare flags
  logic              lt_mode;
  logic [CNT_W-1:0]  lt_c;
  logic [RAND_W-1:0] lt_r;
  logic [NW-1:0]     lt_n;
  logic [LW-1:0]     lt_l;
  logic [63:0]       lt_n64;

  assign {lt_mode, lt_c, lt_r, lt_n} = lc_side[LOG_FRAC_BITS];
  assign lt_l   = lc_res[LOG_FRAC_BITS];
  assign lt_n64 = 64'(lt_n);

  logic             p_vld_r, p_mode_r, p_skip_r, p_force_r, p_big_r;
  logic [CNT_W-1:0] p_c_r;
  logic [NW-1:0]    p_n_r;
  logic [LW-1:0]    p_l_r;
  logic [63:0]      p_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= lc_vld[LOG_FRAC_BITS];
    end
    p_mode_r  <= lt_mode;
    p_c_r     <= lt_c;
    p_n_r     <= lt_n;
    p_l_r     <= lt_l;
    p_skip_r  <= (lt_mode && (lt_c == '0)) || (lt_l == '0);
    p_force_r <= (64'(lt_l) >= lt_n64) || (lt_r == '0);
    p_big_r   <= lt_n64[63:48] != '0;
    p_prod_r  <= lt_r * lt_n64[47:0];
  end

  // ---- decision stage
  logic             d_vld_r, d_go_r, d_mode_r;
  logic [CNT_W-1:0] d_c_r;
  logic [NW-1:0]    d_n_r;
  logic [LW-1:0]    d_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= p_vld_r;
    end
    d_go_r   <= !p_skip_r &&
                (p_force_r || (!p_big_r && (p_prod_r < (64'(p_l_r) << 16))));
    d_mode_r <= p_mode_r;
    d_c_r    <= p_c_r;
    d_n_r    <= p_n_r;
    d_l_r    <= p_l_r;
  end

  // ---- amount = N / L, one quotient bit per cell
  logic [NW:0]          dc_vld;
  logic [NW:0][LW-1:0]  dc_dvs;
  logic [NW:0][LW-1:0]  dc_rem;
  logic [NW:0][NW-1:0]  dc_q;
  logic [NW:0][DSW-1:0] dc_side;

  assign dc_vld[0]  = d_vld_r;
  assign dc_dvs[0]  = d_l_r;
  assign dc_rem[0]  = '0;
  assign dc_q[0]    = d_n_r;
  assign dc_side[0] = {d_go_r, d_mode_r, d_c_r};

  for (genvar g = 0; g < NW; g++) begin : g_div
    pac_div_cell #(.LW(LW), .NW(NW), .SW(DSW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(dc_vld[g]), .dvs_i(dc_dvs[g]), .rem_i(dc_rem[g]), .q_i(dc_q[g]),
      .side_i(dc_side[g]),
      .vld_o(dc_vld[g+1]), .dvs_o(dc_dvs[g+1]), .rem_o(dc_rem[g+1]),
      .q_o(dc_q[g+1]), .side_o(dc_side[g+1])
    );
  end

  // ---- apply update: saturate increments, floor decrements at 1
  localparam logic [63:0] CNT_MAX64 = 64'(32'hFFFF_FFFF >> (32 - CNT_W));

  logic             f_go, f_mode;
  logic [CNT_W-1:0] f_c;
  logic [63:0]      f_amt, f_c64, f_val;

  assign {f_go, f_mode, f_c} = dc_side[NW];

  always_comb begin
    f_amt = 64'(dc_q[NW]);
    f_c64 = 64'(f_c);
    if (!f_go) begin
      f_val = f_c64;
    end else if (!f_mode) begin
      f_val = (f_amt > CNT_MAX64 - f_c64) ? CNT_MAX64 : f_c64 + f_amt;
    end else begin
      f_val = (f_c64 > f_amt) ? f_c64 - f_amt : 64'd1;
    end
  end

  logic                   o_vld_r, o_upd_r;
  logic [CNT_FIELD_W-1:0] o_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      o_upd_r <= 1'b0;
    end else begin
      o_vld_r <= dc_vld[NW];
      o_upd_r <= dc_vld[NW] && f_go;
    end
    o_val_r <= f_val[CNT_FIELD_W-1:0];
  end

  assign out_valid     = o_vld_r;
  assign out_updated   = o_upd_r;
  assign out_new_value = o_val_r;
endmodule
`default_nettype wire

// File: rtl/pac_checker.sv
// pac_checker: port-level assertions for the counter pipeline, plus bind.
// Depends on pac_pkg and the top level probabilistic_approximate_counter.
`timescale 1ns / 1ps
`default_nettype none
module pac_checker #(
  parameter int LOG_FRAC_BITS = 16,
  parameter int COUNTER_BITS  = 32
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            out_valid,
  input wire logic                            out_updated,
  input wire logic [pac_pkg::CNT_FIELD_W-1:0] out_new_value
);
  import pac_pkg::*;

  localparam int CNT_W = (COUNTER_BITS > 32) ? 32 : COUNTER_BITS;
  localparam int NW    = BETA_W + CNT_W + LOG_FRAC_BITS - 8;
  localparam int LAT   = 4 + LOG_FRAC_BITS + NW;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transfer");

  a_upd_qualified: assert property (@(posedge clk) disable iff (!rst_n)
    out_updated |-> out_valid)
    else $error("updated flag outside strobe");

  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CNT_FIELD_W'(out_new_value) >> CNT_W) == '0))
    else $error("result beyond counter width");
endmodule

bind probabilistic_approximate_counter pac_checker #(
  .LOG_FRAC_BITS(LOG_FRAC_BITS),
  .COUNTER_BITS(COUNTER_BITS)
) u_pac_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_updated(out_updated), .out_new_value(out_new_value)
);
`default_nettype wire

// File: test/testbench.sv
// testbench: self-checking bench for probabilistic_approximate_counter.
// Holds its own bit-exact model of the counter update, checked against the DUT.
// Depends on pac_pkg and the probabilistic_approximate_counter RTL.
`timescale 1ns / 1ps

// Scoreboard: keeps register shadows and the queue of predicted results.
class counter_scoreboard;
  bit [31:0] points;
  bit [15:0] beta;
  bit [31:0] exp_value_q[$];
  bit        exp_upd_q[$];
  int        n_errors;

  function new();
    points = pac_pkg::TP_RESET;
    beta = pac_pkg::BETA_RESET;
    n_errors = 0;
  endfunction

  // log2 in Q5.16 by repeated squaring of a Q1.31 mantissa
  function bit [63:0] log2_q16(bit [31:0] x);
    bit [63:0] m;
    bit [63:0] acc;
    int k;
    if (x <= 1) return 0;
    k = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (31 - k);
    acc = k;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      acc = acc << 1;
      if (m >= 64'h1_0000_0000) begin
        acc[0] = 1'b1;
        m = m >> 1;
      end
    end
    return acc;
  endfunction

  // Note an accepted input transfer and queue its expected result.
  function void note_item(bit mode, bit [31:0] c, bit [15:0] r);
    bit [63:0] lg, n, amount, nv;
    bit        go, upd;
    lg = log2_q16(points);
    nv = c;
    upd = 0;
    if (!(mode && c == 0) && lg != 0) begin
      n = (64'(beta) * 64'(c)) << 8;
      if (lg >= n) go = 1;
      else if (r == 0) go = 1;
      else if (n >= 64'h1_0000_0000_0000) go = 0;
      else go = (64'(r) * n) < (lg << 16);
      if (go) begin
        amount = n / lg;
        upd = 1;
        if (!mode) nv = (amount > 64'hFFFF_FFFF - c) ? 64'hFFFF_FFFF : c + amount;
        else nv = (c > amount) ? c - amount : 1;
      end
    end
    exp_value_q.push_back(nv[31:0]);
    exp_upd_q.push_back(upd);
  endfunction

  // Compare one result transfer against the oldest prediction.
  function void check_result(bit [31:0] v, bit u);
    bit [31:0] ev;
    bit        eu;
    if (exp_value_q.size() == 0) begin
      $error("result with no prediction pending: new_value %h", v);
      n_errors++;
      return;
    end
    ev = exp_value_q.pop_front();
    eu = exp_upd_q.pop_front();
    if (ev !== v) begin
      $error("new_value: expected %h, got %h", ev, v);
      n_errors++;
    end
    if (eu !== u) begin
      $error("updated: expected %0d, got %0d", eu, u);
      n_errors++;
    end
  endfunction
endclass

module testbench;
  import pac_pkg::*;

  localparam int LATENCY = 4 + 16 + (8 + 32 + 16);
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [31:0] in_counter_value;
  logic [15:0] in_random_fraction;
  logic        out_valid;
  logic [31:0] out_new_value;
  logic        out_updated;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  counter_scoreboard sb;
  int cycles;

  probabilistic_approximate_counter uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_counter_value(in_counter_value),
    .in_random_fraction(in_random_fraction),
    .out_valid(out_valid), .out_new_value(out_new_value), .out_updated(out_updated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Result side: the receiver cannot stall, so every strobe is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_new_value, out_updated);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Register write; only issued while the pipeline is drained.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOTAL_POINTS) sb.points = data;
    else sb.beta = data[15:0];
  endtask

  // One input transfer: hold start until the edge where busy is low.
  task automatic send_item(bit mode, bit [31:0] c, bit [15:0] r);
    start <= 1'b1;
    in_mode <= mode;
    in_counter_value <= c;
    in_random_fraction <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(mode, c, r);
  endtask

  task automatic go_idle();
    start <= 1'b0;
  endtask

  // Let every prediction drain, then the pipeline tail.
  task automatic drain();
    go_idle();
    @(posedge clk);
    while (sb.exp_value_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Random counter values: half small so updates fire, the rest near the top or full-range.
  function automatic bit [31:0] pick_count();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 16);
      2: return $urandom_range(0, 4096);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 8);
      default: return $urandom;
    endcase
  endfunction

  // Random fractions lean toward zero so the probabilistic branch is hit both ways.
  function automatic bit [15:0] pick_frac();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // A burst of random transfers with random gaps; some bursts run back to back.
  task automatic random_phase(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item($urandom_range(0, 1), pick_count(), pick_frac());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        go_idle();
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    bit [31:0] pts[6];
    bit [15:0] bts[6];
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_counter_value = '0;
    in_random_fraction = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TOTAL_POINTS;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: one point means log2 is zero, so nothing ever updates.
    send_item(0, 5, 0);
    send_item(1, 32'hFFFF_FFFF, 16'hFFFF);
    drain();

    // Directed: zero counter both ways, saturation, decrement underflow, extremes.
    write_reg(REG_TOTAL_POINTS, 1000);
    write_reg(REG_BETA, 256);
    send_item(0, 0, 16'hFFFF);
    send_item(1, 0, 0);
    send_item(0, 32'hFFFF_FFFF, 0);
    send_item(0, 32'hFFFF_FFF0, 0);
    send_item(1, 1, 0);
    send_item(1, 3, 0);
    send_item(1, 32'hFFFF_FFFF, 0);
    send_item(0, 1, 16'hFFFF);
    send_item(0, 2, 16'h8000);
    send_item(1, 100, 16'h0001);
    send_item(0, 32'hAAAA_5555, 16'h5555);
    send_item(1, 32'h5555_AAAA, 16'hAAAA);
    drain();
    // Zero points also gives no update.
    write_reg(REG_TOTAL_POINTS, 0);
    send_item(0, 7, 0);
    drain();
    write_reg(REG_TOTAL_POINTS, 32'hFFFF_FFFF);
    write_reg(REG_BETA, 16'hFFFF);
    send_item(0, 1, 0);
    send_item(1, 32'h8000_0000, 16'h0001);
    drain();
    write_reg(REG_BETA, 1);
    send_item(0, 3, 16'hFFFF);
    send_item(1, 2, 16'h0002);
    drain();

    // Random phases across several register settings, extremes included.
    pts = '{2, 3, 1000, 32'h8000_0000, 32'hFFFF_FFFF, 0};
    bts = '{1, 16'hFFFF, 256, 16'h0080, 16'h1234, 7};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_TOTAL_POINTS, (ph < 6) ? pts[ph] : $urandom);
      write_reg(REG_BETA, (ph < 6) ? bts[ph] : $urandom_range(1, 65535));
      random_phase(250);
      drain();
    end

    if (sb.n_errors == 0 && sb.exp_value_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// File: probabilistic_approximate_counter.f
rtl/pac_pkg.sv
rtl/pac_log_cell.sv
rtl/pac_div_cell.sv
rtl/probabilistic_approximate_counter.sv
rtl/pac_checker.sv
test/testbench.sv
